/* hdl/hsg_pkg.sv */
// Package with the shared types and constants of the hardware semaphore gate unit.
`default_nettype none

package hsg_pkg;

  localparam int unsigned GateCount = 16;
  localparam int unsigned GateIdxW  = (GateCount > 1) ? $clog2(GateCount) : 1;
  localparam int unsigned GateValW  = 4;
  localparam int unsigned MasterW   = 4;
  localparam int unsigned ByteW     = 8;

  localparam logic [ByteW-1:0]   KeyFirst       = 8'he2;
  localparam logic [ByteW-1:0]   KeySecond      = 8'h1d;
  localparam logic [ByteW-1:0]   AllGatesTarget = 8'd64;
  localparam logic [MasterW-1:0] MasterNoLock   = 4'd15;

  typedef enum logic [1:0] {
    MODE_READ_GATE  = 2'd0,
    MODE_WRITE_GATE = 2'd1,
    MODE_READ_RST   = 2'd2,
    MODE_WRITE_RST  = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e               mode;
    logic [MasterW-1:0]  master;
    logic [3:0]          gate_index;
    logic [ByteW-1:0]    write_value;
    logic [ByteW-1:0]    reset_target;
  } item_t;

  typedef struct packed {
    logic [GateValW-1:0] gate_owner;
    logic                accepted;
    logic                reset_phase;
    logic [MasterW-1:0]  reset_master;
    logic [ByteW-1:0]    reset_gate_number;
  } result_t;

  typedef struct packed {
    logic               phase;
    logic [MasterW-1:0] master;
    logic [ByteW-1:0]   target;
  } status_t;

endpackage

`default_nettype wire

/* hdl/hardware_semaphore_gates_top.sv */
// Top level of the hardware semaphore gate unit with stream ports.
//
// The slave stream carries one bus access per transaction: tuser is the access
// mode, and tdata holds the master number, gate index, write value and reset
// target. The master stream returns one result per access: the owner of the
// selected gate after the access, the accepted flag and the state of the
// reset key sequencer.
// An accepted access is held in the input register and evaluated from there;
// its result is then registered in the result register, where it stays valid
// until taken. The unit accepts one access per cycle while the receiver takes
// results; the gate update and the result register are written in the same
// cycle, so each access sees the state left by the one before it.
// Reset frees all gates, clears the key sequencer and empties both registers.
// When the receiver stalls, the result register holds its transaction and one
// further access waits in the input register; after that tready goes low.
`default_nettype none

module hardware_semaphore_gates_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // master [3:0], gate_index [7:4], write_value [15:8], reset_target [23:16]
  input  wire logic [23:0] s_axis_tdata,
  // mode [1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // gate_owner [3:0], accepted [4], reset_phase [5], reset_master [9:6],
  // reset_gate_number [17:10], zero [23:18]
  output logic [23:0]      m_axis_tdata
);
  import hsg_pkg::*;

  item_t   s_item;
  item_t   item;
  logic    item_valid;
  logic    item_ready;
  result_t res;
  status_t status;

  assign s_item.mode         = mode_e'(s_axis_tuser);
  assign s_item.master       = s_axis_tdata[3:0];
  assign s_item.gate_index   = s_axis_tdata[7:4];
  assign s_item.write_value  = s_axis_tdata[15:8];
  assign s_item.reset_target = s_axis_tdata[23:16];

  hsg_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_item_i     (s_item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  hsg_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res),
    .status_o     (status)
  );

  assign m_axis_tdata = {6'b0, res.reset_gate_number, res.reset_master,
                         res.reset_phase, res.accepted, res.gate_owner};

`ifndef NO_ASSERTIONS
  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("Input stalled while the result register could advance.");

  a_result_phase_current : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.reset_phase == status.phase && res.reset_master == status.master))
    else $error("Pending result does not match the key sequencer state.");

  a_result_target_current : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.reset_gate_number == status.target))
    else $error("Pending result does not match the recorded reset target.");

  a_first_key_accepted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(status.phase) |-> (m_axis_tvalid && res.accepted))
    else $error("Key sequencer advanced without an accepted result.");
`endif

endmodule

`default_nettype wire

/* hdl/hsg_in_reg.sv */
// Input register stage that holds one access transaction for the gate logic.
`default_nettype none

module hsg_in_reg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           s_valid_i,
  output logic                s_ready_o,
  input  wire hsg_pkg::item_t s_item_i,
  output logic                item_valid_o,
  input  wire logic           item_ready_i,
  output hsg_pkg::item_t      item_o
);
  import hsg_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  assign s_ready_o    = !valid_q || item_ready_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_comb begin
    valid_d = valid_q;
    if (s_valid_i && s_ready_o) begin
      valid_d = 1'b1;
    end else if (item_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      item_q <= s_item_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/hsg_core.sv */
// Gate array, reset key sequencer and result register of the semaphore unit.
`default_nettype none

module hsg_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           item_valid_i,
  output logic                item_ready_o,
  input  wire hsg_pkg::item_t item_i,
  output logic                res_valid_o,
  input  wire logic           res_ready_i,
  output hsg_pkg::result_t    res_o,
  output hsg_pkg::status_t    status_o
);
  import hsg_pkg::*;

  logic [GateValW-1:0] gate_q [GateCount];
  logic [GateValW-1:0] gate_d [GateCount];
  logic                phase_q, phase_d;
  logic [MasterW-1:0]  rmaster_q, rmaster_d;
  logic [ByteW-1:0]    rtarget_q, rtarget_d;
  logic                res_valid_q;
  result_t             res_q, res_d;

  logic                fire;
  logic                idx_ok;
  logic [GateIdxW-1:0] idx_sel;
  logic [GateIdxW-1:0] tgt_sel;
  logic [GateValW-1:0] cur;
  logic [GateValW-1:0] val4;
  logic [GateValW:0]   mst_plus;
  logic                acc;

  assign item_ready_o = !res_valid_q || res_ready_i;
  assign fire         = item_valid_i && item_ready_o;
  assign res_valid_o  = res_valid_q;
  assign res_o        = res_q;
  assign status_o     = '{phase: phase_q, master: rmaster_q, target: rtarget_q};

  assign idx_ok   = 32'(item_i.gate_index) < GateCount;
  assign idx_sel  = GateIdxW'(item_i.gate_index);
  assign tgt_sel  = GateIdxW'(item_i.reset_target);
  assign cur      = idx_ok ? gate_q[idx_sel] : '0;
  assign val4     = item_i.write_value[GateValW-1:0];
  assign mst_plus = {1'b0, item_i.master} + (GateValW+1)'(1);

  always_comb begin
    gate_d    = gate_q;
    phase_d   = phase_q;
    rmaster_d = rmaster_q;
    rtarget_d = rtarget_q;
    acc       = 1'b0;
    case (item_i.mode)
      MODE_WRITE_GATE: begin
        if (idx_ok) begin
          if (cur == '0 && item_i.master != MasterNoLock && {1'b0, val4} == mst_plus) begin
            gate_d[idx_sel] = val4;
            acc             = 1'b1;
          end else if (cur != '0 && {1'b0, cur} == mst_plus && val4 == '0) begin
            gate_d[idx_sel] = '0;
            acc             = 1'b1;
          end
        end
      end
      MODE_WRITE_RST: begin
        rtarget_d = item_i.reset_target;
        if (!phase_q) begin
          if (item_i.write_value == KeyFirst) begin
            phase_d   = 1'b1;
            rmaster_d = item_i.master;
            acc       = 1'b1;
          end
        end else begin
          phase_d = 1'b0;
          if (item_i.write_value == KeySecond && item_i.master == rmaster_q) begin
            acc = 1'b1;
            if (item_i.reset_target >= AllGatesTarget) begin
              for (int g = 0; g < GateCount; g++) begin
                gate_d[g] = '0;
              end
            end else if (32'(item_i.reset_target) < GateCount) begin
              gate_d[tgt_sel] = '0;
            end
          end
        end
      end
      default: begin
      end
    endcase
    res_d.gate_owner        = idx_ok ? gate_d[idx_sel] : '0;
    res_d.accepted          = acc;
    res_d.reset_phase       = phase_d;
    res_d.reset_master      = rmaster_d;
    res_d.reset_gate_number = rtarget_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < GateCount; g++) begin
        gate_q[g] <= '0;
      end
      phase_q     <= 1'b0;
      rmaster_q   <= '0;
      rtarget_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        gate_q    <= gate_d;
        phase_q   <= phase_d;
        rmaster_q <= rmaster_d;
        rtarget_q <= rtarget_d;
      end
      if (fire) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

/* bench/hsg_checker.sv */
`timescale 1ns / 100ps
// Checker that predicts each semaphore gate access result and compares it with the output stream.
module hsg_checker
  import hsg_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  // master [3:0], gate_index [7:4], write_value [15:8], reset_target [23:16]
  input  wire logic [23:0] s_axis_tdata,
  // mode [1:0]
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // gate_owner [3:0], accepted [4], reset_phase [5], reset_master [9:6],
  // reset_gate_number [17:10], zero [23:18]
  input  wire logic [23:0] m_axis_tdata,
  output int               fail_count_o,
  output int               pending_o
);

  logic [GateValW-1:0] gate_owner_q [GateCount];
  logic                key_phase_q;
  logic [MasterW-1:0]  key_master_q;
  logic [ByteW-1:0]    key_target_q;
  result_t             expected_results [$];

  function automatic result_t apply_access(item_t acc);
    result_t             r;
    logic                done;
    logic [GateValW-1:0] cur;
    int unsigned         val;
    done = 1'b0;
    cur  = '0;
    val  = 32'(acc.write_value[3:0]);
    case (acc.mode)
      MODE_WRITE_GATE: begin
        if (acc.gate_index < GateCount) begin
          cur = gate_owner_q[acc.gate_index];
          if (cur == '0 && acc.master != MasterNoLock && val == int'(acc.master) + 1) begin
            gate_owner_q[acc.gate_index] = val[GateValW-1:0];
            done = 1'b1;
          end else if (cur != '0 && int'(cur) == int'(acc.master) + 1 && val == 0) begin
            gate_owner_q[acc.gate_index] = '0;
            done = 1'b1;
          end
        end
      end
      MODE_WRITE_RST: begin
        key_target_q = acc.reset_target;
        if (!key_phase_q) begin
          if (acc.write_value == KeyFirst) begin
            key_phase_q  = 1'b1;
            key_master_q = acc.master;
            done         = 1'b1;
          end
        end else begin
          key_phase_q = 1'b0;
          if (acc.write_value == KeySecond && acc.master == key_master_q) begin
            if (acc.reset_target >= AllGatesTarget) begin
              foreach (gate_owner_q[g]) gate_owner_q[g] = '0;
            end else if (acc.reset_target < GateCount) begin
              gate_owner_q[acc.reset_target] = '0;
            end
            done = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.gate_owner        = (acc.gate_index < GateCount) ? gate_owner_q[acc.gate_index] : '0;
    r.accepted          = done;
    r.reset_phase       = key_phase_q;
    r.reset_master      = key_master_q;
    r.reset_gate_number = key_target_q;
    return r;
  endfunction

  function automatic bit field_matches(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t want;
    item_t   acc;
    bit      ok;
    if (!rst_ni) begin
      foreach (gate_owner_q[g]) gate_owner_q[g] = '0;
      key_phase_q  = 1'b0;
      key_master_q = '0;
      key_target_q = '0;
      expected_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result transaction with no access pending, actual %0h",
                   $time, m_axis_tdata);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          ok = 1'b1;
          ok &= field_matches("gate_owner", 32'(want.gate_owner), 32'(m_axis_tdata[3:0]));
          ok &= field_matches("accepted", 32'(want.accepted), 32'(m_axis_tdata[4]));
          ok &= field_matches("reset_phase", 32'(want.reset_phase), 32'(m_axis_tdata[5]));
          ok &= field_matches("reset_master", 32'(want.reset_master),
                              32'(m_axis_tdata[9:6]));
          ok &= field_matches("reset_gate_number", 32'(want.reset_gate_number),
                              32'(m_axis_tdata[17:10]));
          if (!ok) fail_count_o++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        acc.mode         = mode_e'(s_axis_tuser);
        acc.master       = s_axis_tdata[3:0];
        acc.gate_index   = s_axis_tdata[7:4];
        acc.write_value  = s_axis_tdata[15:8];
        acc.reset_target = s_axis_tdata[23:16];
        expected_results.push_back(apply_access(acc));
      end
      pending_o = expected_results.size();
    end
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Top of the testbench: clock, reset, access stimulus, receiver stalls and the verdict.
module tb_top;
  import hsg_pkg::*;

  localparam int LimitCycles    = 400000;
  localparam int PressureCycles = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;

  int fail_count;
  int pending;
  int sent_count  = 0;
  int cycle_count = 0;
  bit hold_off    = 1'b0;
  bit gapless     = 1'b0;

  always #4 clk_i = ~clk_i;

  hardware_semaphore_gates_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  hsg_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  task automatic send_access(input mode_e mode, input logic [3:0] mst, input logic [3:0] idx,
                             input logic [7:0] val, input logic [7:0] tgt);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (gapless || r < 55) gap = 0;
    else if (r < 93) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {tgt, val, idx, mst};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_count++;
  endtask

  task automatic key_sequence(input logic [3:0] first_mst, input logic [3:0] second_mst,
                              input logic [7:0] second_key, input logic [7:0] tgt);
    send_access(MODE_WRITE_RST, first_mst, 4'($urandom_range(0, 15)), KeyFirst,
                8'($urandom_range(0, 255)));
    send_access(MODE_WRITE_RST, second_mst, 4'($urandom_range(0, 15)), second_key, tgt);
  endtask

  initial begin : receiver
    int run_left;
    bit stalling;
    run_left = 0;
    stalling = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (run_left == 0) begin
        stalling = ($urandom_range(0, 99) < 30);
        if (!stalling) run_left = $urandom_range(1, 40);
        else if ($urandom_range(0, 9) < 8) run_left = $urandom_range(1, 3);
        else run_left = $urandom_range(10, 50);
      end
      run_left--;
      m_axis_tready <= !(stalling || hold_off);
    end
  end

  initial begin : pressure
    wait (sent_count >= 400);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (PressureCycles) @(posedge clk_i);
    hold_off = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LimitCycles) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [3:0] mst;
    logic [3:0] idx;
    logic [3:0] low;
    logic [3:0] high;
    logic [7:0] tgt;
    int         kind;
    int         r;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed accesses: lock rules, master fifteen, key sequence cases.
    send_access(MODE_READ_GATE, 4'd0, 4'd0, 8'h00, 8'h00);
    send_access(MODE_READ_RST, 4'd15, 4'd15, 8'hff, 8'hff);
    send_access(MODE_WRITE_GATE, 4'd0, 4'd0, 8'h01, 8'h00);
    send_access(MODE_WRITE_GATE, 4'd1, 4'd0, 8'h02, 8'h00);
    send_access(MODE_WRITE_GATE, 4'd0, 4'd0, 8'h01, 8'h00);
    send_access(MODE_WRITE_GATE, 4'd1, 4'd0, 8'h00, 8'h00);
    send_access(MODE_WRITE_GATE, 4'd0, 4'd0, 8'h05, 8'h00);
    send_access(MODE_WRITE_GATE, 4'd15, 4'd15, 8'h00, 8'h00);
    send_access(MODE_WRITE_GATE, 4'd15, 4'd15, 8'h0f, 8'h00);
    send_access(MODE_WRITE_GATE, 4'd14, 4'd15, 8'hff, 8'h00);
    send_access(MODE_WRITE_GATE, 4'd0, 4'd0, 8'hf0, 8'h00);
    send_access(MODE_WRITE_RST, 4'd2, 4'd0, KeySecond, 8'd3);
    key_sequence(4'd2, 4'd3, KeySecond, 8'd255);
    key_sequence(4'd4, 4'd4, 8'h55, 8'd15);
    key_sequence(4'd2, 4'd2, KeySecond, 8'd15);
    send_access(MODE_READ_GATE, 4'd0, 4'd15, 8'h00, 8'h00);
    send_access(MODE_WRITE_GATE, 4'd7, 4'd9, 8'h08, 8'h00);
    key_sequence(4'd5, 4'd5, KeySecond, 8'd40);
    key_sequence(4'd9, 4'd9, KeySecond, 8'd64);
    send_access(MODE_READ_GATE, 4'd0, 4'd9, 8'h00, 8'h00);

    for (int blk = 0; blk < 10; blk++) begin
      gapless = ($urandom_range(0, 3) == 0);
      repeat (86) begin
        kind = $urandom_range(0, 99);
        mst  = 4'($urandom_range(0, 15));
        idx  = 4'($urandom_range(0, 15));
        r    = $urandom_range(0, 99);
        if (r < 50) tgt = 8'($urandom_range(0, 15));
        else if (r < 70) tgt = 8'($urandom_range(16, 63));
        else tgt = 8'($urandom_range(64, 255));
        if (kind < 50) begin
          r = $urandom_range(0, 9);
          if (r < 4) low = mst + 4'd1;
          else if (r < 7) low = 4'd0;
          else low = 4'($urandom_range(0, 15));
          high = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd0;
          send_access(MODE_WRITE_GATE, mst, idx, {high, low}, 8'($urandom_range(0, 255)));
        end else if (kind < 68) begin
          send_access(MODE_READ_GATE, mst, idx, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
        end else if (kind < 84) begin
          key_sequence(mst,
                       ($urandom_range(0, 9) < 8) ? mst : 4'($urandom_range(0, 15)),
                       ($urandom_range(0, 9) < 8) ? KeySecond : 8'($urandom_range(0, 255)),
                       tgt);
        end else if (kind < 92) begin
          send_access(MODE_WRITE_RST, mst, idx,
                      ($urandom_range(0, 3) == 0) ? KeyFirst : 8'($urandom_range(0, 255)), tgt);
        end else begin
          send_access(MODE_READ_RST, mst, idx, 8'($urandom_range(0, 255)), tgt);
        end
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
